// ===== rtl/scancode_to_ascii_decoder_macros.svh =====
// Assertion macros shared by the scan code decoder RTL.
`ifndef SCANCODE_TO_ASCII_DECODER_MACROS_SVH
`define SCANCODE_TO_ASCII_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SC2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("scan code decoder check failed");

// Next-cycle implication, checked outside reset.
`define SC2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("scan code decoder check failed");

`else

`define SC2A_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SC2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sc2a_pkg.sv =====
// Package with the scan code constants, action codes and decode function.
package sc2a_pkg;

	// Action codes carried on the action output.
	typedef enum logic [3:0] {
		ACT_CHAR       = 4'd0,
		ACT_ERASE      = 4'd1,
		ACT_WORD_ERASE = 4'd2,
		ACT_RED        = 4'd3,
		ACT_LEFT       = 4'd4,
		ACT_UP         = 4'd5,
		ACT_RIGHT      = 4'd6,
		ACT_DOWN       = 4'd7,
		ACT_CLEAR_HOME = 4'd8,
		ACT_UNKNOWN    = 4'd9
	} action_t;

	// Set 1 scan codes with special meaning.
	localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
	localparam logic [7:0] SC_ENTER       = 8'h1C;
	localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
	localparam logic [7:0] SC_SHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_SPACE       = 8'h39;
	localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
	localparam logic [7:0] SC_NUM_LOCK    = 8'h45;
	localparam logic [7:0] SC_UP          = 8'h48;
	localparam logic [7:0] SC_LEFT        = 8'h4B;
	localparam logic [7:0] SC_RIGHT       = 8'h4D;
	localparam logic [7:0] SC_END         = 8'h4F;
	localparam logic [7:0] SC_DOWN        = 8'h50;
	localparam logic [7:0] SC_INSERT      = 8'h52;
	localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
	localparam logic [7:0] SC_SHIFT_BREAK = 8'hAA;

	// First and last codes of the four printable rows.
	localparam logic [7:0] SC_NUM_FIRST = 8'h02;
	localparam logic [7:0] SC_NUM_LAST  = 8'h0D;
	localparam logic [7:0] SC_TOP_FIRST = 8'h10;
	localparam logic [7:0] SC_TOP_LAST  = 8'h1B;
	localparam logic [7:0] SC_MID_FIRST = 8'h1E;
	localparam logic [7:0] SC_MID_LAST  = 8'h28;
	localparam logic [7:0] SC_BOT_FIRST = 8'h2C;
	localparam logic [7:0] SC_BOT_LAST  = 8'h35;

	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	// Row layouts, padded with blanks to a common length; first key at the top byte.
	localparam int ROW_LEN = 12;
	typedef logic [8*ROW_LEN-1:0] row_t;
	localparam row_t ROW_NUM_LO = "1234567890-=";
	localparam row_t ROW_NUM_HI = "!@#$%^&*()_+";
	localparam row_t ROW_TOP_LO = "qwertyuiop[]";
	localparam row_t ROW_TOP_HI = "QWERTYUIOP{}";
	localparam row_t ROW_MID_LO = "asdfghjkl;' ";
	localparam row_t ROW_MID_HI = "ASDFGHJKL:\" ";
	localparam row_t ROW_BOT_LO = "zxcvbnm,./  ";
	localparam row_t ROW_BOT_HI = "ZXCVBNM<>?  ";

	// Result of decoding one scan code against the current flags.
	typedef struct packed {
		logic       emit;
		action_t    action;
		logic [7:0] value;
		logic       shift_next;
		logic       ctrl_next;
	} dec_t;

	// Picks the character at a key position within a row.
	function automatic logic [7:0] row_char(row_t row, logic [3:0] idx);
		return row[8*(ROW_LEN-1-int'(idx)) +: 8];
	endfunction

	// Decodes one scan code and gives the updated flags.
	function automatic dec_t decode_code(logic [7:0] code, logic shift, logic ctrl);
		dec_t d;
		d.emit       = 1'b1;
		d.action     = ACT_UNKNOWN;
		d.value      = code;
		d.shift_next = shift;
		d.ctrl_next  = ctrl;
		if (code[7]) begin
			// Break codes never give a result.
			d.emit  = 1'b0;
			d.value = '0;
			if (code == SC_SHIFT_BREAK) begin
				d.shift_next = !shift;
			end else if (code == SC_CTRL_BREAK) begin
				d.ctrl_next = 1'b0;
			end
		end else begin
			case (code) inside
				[SC_NUM_FIRST:SC_NUM_LAST]: begin
					d.action = ACT_CHAR;
					d.value  = row_char(shift ? ROW_NUM_HI : ROW_NUM_LO,
						4'(code - SC_NUM_FIRST));
				end
				[SC_TOP_FIRST:SC_TOP_LAST]: begin
					d.action = ACT_CHAR;
					d.value  = row_char(shift ? ROW_TOP_HI : ROW_TOP_LO,
						4'(code - SC_TOP_FIRST));
				end
				[SC_MID_FIRST:SC_MID_LAST]: begin
					d.action = ACT_CHAR;
					d.value  = row_char(shift ? ROW_MID_HI : ROW_MID_LO,
						4'(code - SC_MID_FIRST));
				end
				[SC_BOT_FIRST:SC_BOT_LAST]: begin
					d.action = ACT_CHAR;
					d.value  = row_char(shift ? ROW_BOT_HI : ROW_BOT_LO,
						4'(code - SC_BOT_FIRST));
				end
				SC_BACKSPACE: begin
					d.action = ctrl ? ACT_WORD_ERASE : ACT_ERASE;
					d.value  = '0;
				end
				SC_ENTER: begin
					d.action = ACT_CHAR;
					d.value  = ASCII_LF;
				end
				SC_SPACE: begin
					d.action = ACT_CHAR;
					d.value  = ASCII_SPACE;
				end
				SC_SHIFT_MAKE: begin
					d.emit       = 1'b0;
					d.value      = '0;
					d.shift_next = 1'b1;
				end
				SC_CTRL_MAKE: begin
					d.emit      = 1'b0;
					d.value     = '0;
					d.ctrl_next = 1'b1;
				end
				SC_CAPS_LOCK: begin
					d.emit       = 1'b0;
					d.value      = '0;
					d.shift_next = !shift;
				end
				SC_NUM_LOCK: begin
					d.emit  = 1'b0;
					d.value = '0;
				end
				SC_INSERT: begin
					d.action = ACT_RED;
					d.value  = '0;
				end
				SC_LEFT: begin
					d.action = ACT_LEFT;
					d.value  = '0;
				end
				SC_UP: begin
					d.action = ACT_UP;
					d.value  = '0;
				end
				SC_RIGHT: begin
					d.action = ACT_RIGHT;
					d.value  = '0;
				end
				SC_DOWN: begin
					d.action = ACT_DOWN;
					d.value  = '0;
				end
				SC_END: begin
					d.action = ACT_CLEAR_HOME;
					d.value  = '0;
				end
				default: begin
					// Unknown make code goes out raw.
					d.action = ACT_UNKNOWN;
					d.value  = code;
				end
			endcase
		end
		return d;
	endfunction

endpackage

// ===== rtl/scancode_to_ascii_decoder.sv =====
// Set 1 keyboard scan code decoder with shift and ctrl tracking.
//
// Input channel: scan_code with in_valid / in_ready, one byte per request.
// Output channel: action and value with out_valid / out_ready. A make code
// of a printable key, Enter or space gives a character; backspace, Insert,
// the arrows and End give commands; an unrecognized make code goes out raw
// with the unknown action. Modifier keys, num lock and break codes update
// the flags or are dropped and give no output request.
// A byte taken into the input register is decoded from there, and its result
// is loaded into the output register once that register is free. Throughput
// is one byte per cycle while the receiver does not stall; the single decode
// stage between the two registers sets that figure.
// The flags are updated as each byte leaves the input register, so every
// byte is decoded against the flags left by the byte before it.
// Reset clears both registers' valid bits and the shift and ctrl flags.
// When the receiver stalls, the result holds in the output register and
// one more byte waits in the input register; in_ready then drops.
`include "scancode_to_ascii_decoder_macros.svh"

module scancode_to_ascii_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] action,
	output logic [7:0] value
);
	import sc2a_pkg::*;

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       valid_s2;
	action_t    action_s2;
	logic [7:0] value_s2;
	logic       shift_q;
	logic       ctrl_q;
	logic       s2_free;
	logic       s1_fire;
	dec_t       dec;

	// Handshake: the input stage moves on whenever the output stage can take it.
	assign s2_free  = !valid_s2 || out_ready;
	assign s1_fire  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Decode the held byte against the current flags.
	assign dec = decode_code(code_s1, shift_q, ctrl_q);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= scan_code;
		end
	end

	// Output register and flag update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= s1_fire && dec.emit;
			end
			if (s1_fire) begin
				shift_q <= dec.shift_next;
				ctrl_q  <= dec.ctrl_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			action_s2 <= dec.action;
			value_s2  <= dec.value;
		end
	end

	assign out_valid = valid_s2;
	assign action    = action_s2;
	assign value     = value_s2;

	// A break code never leaves a result behind.
	`SC2A_ASSERT_NEXT(a_break_no_result, clk, arst_n, s1_fire && code_s1[7], !out_valid)
	// A ctrl press is seen by the next byte.
	`SC2A_ASSERT_NEXT(a_ctrl_set, clk, arst_n, s1_fire && code_s1 == SC_CTRL_MAKE, ctrl_q)
	// The input only backs up when both stages are full and the output stalls.
	`SC2A_ASSERT_NOW(a_ready_stall, clk, arst_n, !in_ready, valid_s1 && valid_s2 && !out_ready)
	// A raw code is always a make code.
	`SC2A_ASSERT_NOW(a_unknown_make, clk, arst_n, out_valid && action == ACT_UNKNOWN, !value[7])

endmodule
